/* hdl/lzss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared sizes, register map and result kind codes.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int WINDOW_DEPTH   = 4096;
  localparam int WIN_BITS       = $clog2(WINDOW_DEPTH);
  localparam int OFF_BITS       = WIN_BITS + 1;
  localparam int COUNT_BITS     = 24;
  localparam int CAP_BITS       = 24;
  localparam int OUT_COUNT_BITS = 24;
  localparam int CMP_BITS       = 33;
  localparam int LEN_BITS       = 5;
  localparam int MIN_MATCH      = 3;
  localparam int BYTE_BITS      = 8;
  localparam int ADDR_BITS      = 3;
  localparam int DATA_BITS      = 32;

  // register index, taken from paddr[2]
  localparam logic REG_OUT_CAPACITY = 1'b0;
  localparam logic [CAP_BITS-1:0] CAP_RESET = '1;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

endpackage

/* hdl/lzss_stream_decompressor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS stream decompressor
// One compressed byte per input transaction, one decompressed byte or status
// result per output transaction, 4096-byte history in a synchronous RAM.
// ----------------------------------------------------------------------------
// Rate: a flag byte or the low byte of a back-reference is taken in and
// stored. A literal is accepted, then emitted. A back-reference of up to
// 18 bytes is read from the history RAM, which has one registered read port,
// and the copy loop emits one byte per cycle through it while the output does
// not stall. An end or error result is emitted from its own state. The
// history needs no clearing after reset, since a valid stream never reads a
// byte that was not written in the current frame.
// Output stalls hold the copy loop; the input is taken only between items.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [31:8] out_count
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast,   // out_final
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lzss_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lzss_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lzss_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);

  typedef enum logic [2:0] {S_IN, S_LIT, S_COPY, S_ERR, S_END} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_REF_HI} phase_t;

  state_t state;
  phase_t phase;

  logic [lzss_pkg::BYTE_BITS-1:0]  flag_bits;
  logic [2:0]                      token_index;
  logic [lzss_pkg::BYTE_BITS-1:0]  held_low_byte;
  logic [lzss_pkg::COUNT_BITS-1:0] produced_count;
  logic                            failed;
  logic [lzss_pkg::CAP_BITS-1:0]   out_capacity;
  logic                            last_item;
  logic [lzss_pkg::BYTE_BITS-1:0]  lit_byte;

  // copy loop
  logic [lzss_pkg::WIN_BITS-1:0]   src;
  logic [lzss_pkg::LEN_BITS-1:0]   rd_left;
  logic [lzss_pkg::LEN_BITS-1:0]   emit_left;
  logic                            b_valid;
  logic                            b_fwd;
  logic [lzss_pkg::BYTE_BITS-1:0]  b_fwd_data;
  logic                            copy_off_one;

  // history RAM
  logic [lzss_pkg::BYTE_BITS-1:0]  hist [lzss_pkg::WINDOW_DEPTH];
  logic [lzss_pkg::BYTE_BITS-1:0]  hist_rdata;
  logic [lzss_pkg::WIN_BITS-1:0]   wr_addr;

  logic                            out_free;
  logic                            in_take;
  logic                            lit_take;
  logic                            copy_take;
  logic                            data_emit;
  logic                            res_load;
  logic [lzss_pkg::BYTE_BITS-1:0]  data_val;
  logic                            data_final;
  logic                            rd_issue;
  logic                            fwd_hit;
  logic                            frame_clear;
  logic                            cfg_write;
  logic [lzss_pkg::OFF_BITS-1:0]   ref_off;
  logic [lzss_pkg::LEN_BITS-1:0]   ref_len;
  logic                            ref_too_far;
  logic                            ref_over;
  logic                            lit_full;
  logic [lzss_pkg::COUNT_BITS-1:0] count_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == lzss_pkg::REG_OUT_CAPACITY) ?
                     lzss_pkg::DATA_BITS'(out_capacity) : '0;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IN);
  assign in_take   = s_tvalid && s_tready;
  assign lit_take  = (state == S_LIT) && out_free;
  assign copy_take = (state == S_COPY) && b_valid && out_free;
  assign data_emit = lit_take || copy_take;
  assign res_load  = data_emit || (((state == S_ERR) || (state == S_END)) && out_free);
  assign data_val  = (state == S_LIT) ? lit_byte : (b_fwd ? b_fwd_data : hist_rdata);
  assign data_final = !last_item && ((state == S_LIT) || (emit_left == lzss_pkg::LEN_BITS'(1)));
  assign rd_issue  = (state == S_COPY) && (rd_left != '0) && (!b_valid || copy_take);
  assign wr_addr   = produced_count[lzss_pkg::WIN_BITS-1:0];
  assign fwd_hit   = data_emit && (wr_addr == src);
  assign count_next = lzss_pkg::COUNT_BITS'(produced_count + 1'b1);

  assign ref_off = lzss_pkg::OFF_BITS'({s_tdata[7:4], held_low_byte}) + 1'b1;
  assign ref_len = lzss_pkg::LEN_BITS'(s_tdata[3:0]) + lzss_pkg::LEN_BITS'(lzss_pkg::MIN_MATCH);
  assign ref_too_far = lzss_pkg::CMP_BITS'(produced_count) < lzss_pkg::CMP_BITS'(ref_off);
  assign ref_over = (lzss_pkg::CMP_BITS'(produced_count) + lzss_pkg::CMP_BITS'(ref_len)) >
                    lzss_pkg::CMP_BITS'(out_capacity);
  assign lit_full = lzss_pkg::CMP_BITS'(produced_count) >= lzss_pkg::CMP_BITS'(out_capacity);

  assign frame_clear = (in_take && failed && s_tlast) ||
                       ((state == S_ERR) && out_free && last_item) ||
                       ((state == S_END) && out_free);

  always_ff @(posedge clk) begin
    if (data_emit) begin
      hist[wr_addr] <= data_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      hist_rdata <= hist[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IN;
      phase          <= PH_FLAG;
      flag_bits      <= '0;
      token_index    <= '0;
      held_low_byte  <= '0;
      produced_count <= '0;
      failed         <= 1'b0;
      out_capacity   <= lzss_pkg::CAP_RESET;
      last_item      <= 1'b0;
      m_tvalid       <= 1'b0;
      b_valid        <= 1'b0;
      rd_left        <= '0;
      emit_left      <= '0;
      copy_off_one   <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == lzss_pkg::REG_OUT_CAPACITY) begin
        out_capacity <= pwdata[lzss_pkg::CAP_BITS-1:0];
      end

      if (m_tvalid && m_tready && !res_load) begin
        m_tvalid <= 1'b0;
      end

      if (data_emit) begin
        produced_count <= count_next;
        m_tvalid       <= 1'b1;
        m_tdata        <= {lzss_pkg::OUT_COUNT_BITS'(count_next), data_val};
        m_tuser        <= lzss_pkg::KIND_DATA;
        m_tlast        <= data_final;
      end

      case (state)
        S_IN: begin
          if (in_take && !failed) begin
            last_item <= s_tlast;
            case (phase)
              PH_TOKEN: begin
                if (flag_bits[token_index]) begin
                  held_low_byte <= s_tdata;
                  phase         <= PH_REF_HI;
                  // drop a reference cut off at stream end
                  if (s_tlast) state <= S_END;
                end else if (lit_full) begin
                  state <= S_ERR;
                end else begin
                  lit_byte <= s_tdata;
                  state    <= S_LIT;
                end
              end
              PH_REF_HI: begin
                if (ref_too_far || ref_over) begin
                  state <= S_ERR;
                end else begin
                  src          <= wr_addr - ref_off[lzss_pkg::WIN_BITS-1:0];
                  rd_left      <= ref_len;
                  emit_left    <= ref_len;
                  copy_off_one <= (ref_off == lzss_pkg::OFF_BITS'(1));
                  state        <= S_COPY;
                end
              end
              default: begin
                flag_bits   <= s_tdata;
                token_index <= '0;
                phase       <= PH_TOKEN;
                if (s_tlast) state <= S_END;
              end
            endcase
          end
        end
        S_LIT: begin
          if (lit_take) begin
            token_index <= token_index + 1'b1;
            phase       <= (&token_index) ? PH_FLAG : PH_TOKEN;
            state       <= last_item ? S_END : S_IN;
          end
        end
        S_COPY: begin
          if (rd_issue) begin
            src        <= src + 1'b1;
            rd_left    <= rd_left - 1'b1;
            b_valid    <= 1'b1;
            // same-cycle write to the byte being read: take the written value
            b_fwd      <= fwd_hit;
            b_fwd_data <= data_val;
          end else if (copy_take) begin
            b_valid <= 1'b0;
          end
          if (copy_take) begin
            emit_left <= emit_left - 1'b1;
            if (emit_left == lzss_pkg::LEN_BITS'(1)) begin
              token_index <= token_index + 1'b1;
              phase       <= (&token_index) ? PH_FLAG : PH_TOKEN;
              state       <= last_item ? S_END : S_IN;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {lzss_pkg::OUT_COUNT_BITS'(produced_count), 8'h00};
            m_tuser  <= lzss_pkg::KIND_ERROR;
            m_tlast  <= 1'b1;
            // on the last item the frame is cleared instead
            if (!last_item) failed <= 1'b1;
            state    <= S_IN;
          end
        end
        S_END: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {lzss_pkg::OUT_COUNT_BITS'(produced_count), 8'h00};
            m_tuser  <= lzss_pkg::KIND_END;
            m_tlast  <= 1'b1;
            state    <= S_IN;
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase

      if (frame_clear) begin
        flag_bits      <= '0;
        token_index    <= '0;
        phase          <= PH_FLAG;
        held_low_byte  <= '0;
        produced_count <= '0;
        failed         <= 1'b0;
      end
    end
  end

  // forwarding is only needed when a copy reads the byte written just before
  a_fwd_off_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) && b_valid && b_fwd |-> copy_off_one)
    else $error("history forward outside an offset-one copy");

  // reads in flight plus reads to issue always match bytes left to emit
  a_copy_balance: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |->
      (lzss_pkg::LEN_BITS'(rd_left) + lzss_pkg::LEN_BITS'(b_valid) == emit_left))
    else $error("copy read and emit counts out of step");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != lzss_pkg::KIND_DATA) |-> m_tlast)
    else $error("end or error result not marked final");

  a_copy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (emit_left != '0))
    else $error("copy loop running with nothing left");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    $past(in_take) && !$past(failed) && ($past(phase) == PH_TOKEN) &&
    !$past(flag_bits[token_index]) && !$past(lit_full) |-> (state == S_LIT))
    else $error("literal not scheduled for output");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS stream decompressor testbench
// Sends compressed frames byte by byte with random gaps and stalls. An
// in-bench decoder predicts every data, end and error result. A checker
// compares each output transaction with the oldest prediction. Directed frames
// cover literals, overlapping copies, stream ends in every phase, offset errors
// and capacity errors. Random frames and capacity settings follow them.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [lzss_pkg::ADDR_BITS-1:0] CAP_ADDR = {lzss_pkg::REG_OUT_CAPACITY, 2'b00};
  localparam int RANDOM_ITEMS = 100;
  localparam int SETTLE_CYCLES = 30;

  typedef enum logic [1:0] {PH_AWAIT_FLAG, PH_TOKEN, PH_REF_HI} dec_phase_t;

  typedef struct {
    logic [7:0]  data_b;
    logic [1:0]  kind;
    logic [23:0] count;
    logic        is_last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] in_byte
  logic        s_tlast = 1'b0;  // in_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [7:0] out_byte, [31:8] out_count
  logic [1:0]  m_tuser;         // [1:0] out_kind
  logic        m_tlast;         // out_final

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [lzss_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [lzss_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [lzss_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  lzss_stream_decompressor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // decoder state
  logic [7:0]  win_mem [0:lzss_pkg::WINDOW_DEPTH-1];
  logic [7:0]  flags;
  logic [2:0]  tok_idx;
  dec_phase_t  dec_phase;
  logic [7:0]  held_lo;
  logic [23:0] produced;
  logic        frame_failed;
  logic [23:0] capacity;

  decoded_t expected_out[$];

  int mismatches = 0;
  int bytes_checked = 0;
  int ends_checked = 0;
  int errors_checked = 0;
  int items_sent = 0;
  int cap_writes = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still pending", expected_out.size());
    $display("FAILURE");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void restart_frame();
    flags = '0;
    tok_idx = '0;
    dec_phase = PH_AWAIT_FLAG;
    held_lo = '0;
    produced = '0;
    frame_failed = 1'b0;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic [1:0] kind);
    decoded_t r;
    r.data_b = b;
    r.kind = kind;
    r.count = produced;
    r.is_last = 1'b0;
    expected_out.push_back(r);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    win_mem[produced[lzss_pkg::WIN_BITS-1:0]] = b;
    produced = produced + 24'd1;
    push_result(b, lzss_pkg::KIND_DATA);
  endfunction

  function automatic void advance_token();
    tok_idx = tok_idx + 3'd1;
    dec_phase = (tok_idx == 3'd0) ? PH_AWAIT_FLAG : PH_TOKEN;
  endfunction

  // Decode one compressed byte and queue the results it causes.
  function automatic void predict_decode(input logic [7:0] b, input logic last);
    int unsigned n_out;
    int unsigned off;
    int unsigned len;
    int unsigned src;
    n_out = 0;
    if (frame_failed) begin
      if (last) restart_frame();
      return;
    end
    case (dec_phase)
      PH_TOKEN: begin
        if (flags[tok_idx]) begin
          held_lo = b;
          dec_phase = PH_REF_HI;
        end else if (produced >= capacity) begin
          frame_failed = 1'b1;
        end else begin
          put_byte(b);
          n_out++;
          advance_token();
        end
      end
      PH_REF_HI: begin
        off = {b[7:4], held_lo} + 1;
        len = b[3:0] + lzss_pkg::MIN_MATCH;
        if (produced < off || produced + len > capacity) begin
          frame_failed = 1'b1;
        end else begin
          for (int k = 0; k < len; k++) begin
            src = produced - off;
            put_byte(win_mem[src[lzss_pkg::WIN_BITS-1:0]]);
            n_out++;
          end
          advance_token();
        end
      end
      default: begin
        flags = b;
        tok_idx = '0;
        dec_phase = PH_TOKEN;
      end
    endcase
    if (frame_failed) begin
      push_result(8'h00, lzss_pkg::KIND_ERROR);
      n_out++;
      if (last) restart_frame();
    end else if (last) begin
      push_result(8'h00, lzss_pkg::KIND_END);
      n_out++;
      restart_frame();
    end
    if (n_out > 0) expected_out[$].is_last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_decode(b, last);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fb[$]);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  // Drop valid, drain every pending result, then let the block go idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_out.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [lzss_pkg::ADDR_BITS-1:0] a,
                           input logic [lzss_pkg::DATA_BITS-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [lzss_pkg::ADDR_BITS-1:0] a,
                          output logic [lzss_pkg::DATA_BITS-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_reg();
    logic [lzss_pkg::DATA_BITS-1:0] rd;
    apb_read(CAP_ADDR, rd);
    if (rd[lzss_pkg::CAP_BITS-1:0] !== capacity)
      log_mismatch($sformatf("out_capacity reads %0h, expected %0h", rd, capacity));
  endtask

  task automatic set_capacity(input logic [23:0] v);
    settle();
    apb_write(CAP_ADDR, {{(lzss_pkg::DATA_BITS-lzss_pkg::CAP_BITS){1'b0}}, v});
    capacity = v;
    cap_writes++;
    check_capacity_reg();
  endtask

  // Output side: random stalls, compare each transaction with the oldest prediction.
  initial begin : result_checker
    int stall;
    decoded_t e;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (expected_out.size() == 0) begin
        log_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d",
                               m_tuser, m_tdata[7:0], m_tdata[31:8]));
      end else begin
        e = expected_out.pop_front();
        if (m_tuser !== e.kind)
          log_mismatch($sformatf("kind %0d, expected %0d", m_tuser, e.kind));
        if (m_tdata[7:0] !== e.data_b)
          log_mismatch($sformatf("byte %02h, expected %02h (count %0d)",
                                 m_tdata[7:0], e.data_b, e.count));
        if (m_tdata[31:8] !== e.count)
          log_mismatch($sformatf("count %0d, expected %0d", m_tdata[31:8], e.count));
        if (m_tlast !== e.is_last)
          log_mismatch($sformatf("tlast %b, expected %b (count %0d)",
                                 m_tlast, e.is_last, e.count));
        case (e.kind)
          lzss_pkg::KIND_DATA: bytes_checked++;
          lzss_pkg::KIND_END:  ends_checked++;
          default:             errors_checked++;
        endcase
      end
    end
  end

  task automatic test_reset_register();
    check_capacity_reg();
  endtask

  task automatic test_literals_and_copies();
    // literal, overlapping copy of offset 1 and length 18, literals, short copy,
    // literals, then the stream ends on a fresh flag byte
    send_frame('{8'h22, 8'h00, 8'h00, 8'h0F, 8'hFF, 8'h5A, 8'hC3,
                 8'h03, 8'h00, 8'h7E, 8'h01, 8'hFF});
  endtask

  task automatic test_stream_end_cases();
    send_frame('{8'h01, 8'h00});      // cut inside a back-reference
    send_frame('{8'h00, 8'h42});      // last on a literal
    send_frame('{8'h80});             // last on the flag byte
  endtask

  task automatic test_offset_error();
    // offset 4096 on an empty frame, then trailing bytes are ignored
    send_frame('{8'h01, 8'hFF, 8'hFF, 8'h12, 8'h34});
  endtask

  task automatic test_capacity();
    set_capacity(24'd3);
    send_frame('{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55});
    set_capacity(24'd4);
    send_frame('{8'h02, 8'h99, 8'h00, 8'h01});    // copy overruns on the last item
    set_capacity(24'd0);
    send_frame('{8'h00, 8'hEE});
    set_capacity(lzss_pkg::CAP_RESET);
  endtask

  task automatic random_frame(output int n_items);
    logic [7:0]  fb[$];
    logic [11:0] code;
    int          produced_g;
    int          n_tokens;
    int          fi;
    int          off;
    int          len;
    bit          is_ref;
    bit          bad;
    bit          last_ref;
    produced_g = 0;
    last_ref = 1'b0;
    fi = 0;
    if ($urandom_range(0, 9) == 0) begin
      // noise
      repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_tokens = $urandom_range(1, 20);
      for (int t = 0; t < n_tokens; t++) begin
        if (t % 8 == 0) begin
          fi = fb.size();
          fb.push_back(8'h00);
        end
        is_ref = ($urandom_range(0, 2) == 0);
        bad = ($urandom_range(0, 19) == 0);
        if (is_ref && produced_g == 0 && !bad) is_ref = 1'b0;
        last_ref = is_ref;
        if (is_ref) begin
          len = $urandom_range(lzss_pkg::MIN_MATCH, 18);
          if (bad || produced_g == 0)
            off = (produced_g >= lzss_pkg::WINDOW_DEPTH) ?
                  lzss_pkg::WINDOW_DEPTH :
                  $urandom_range(produced_g + 1, lzss_pkg::WINDOW_DEPTH);
          else
            off = $urandom_range(1, (produced_g < lzss_pkg::WINDOW_DEPTH) ?
                                    produced_g : lzss_pkg::WINDOW_DEPTH);
          code = 12'(off - 1);
          fb[fi][t % 8] = 1'b1;
          fb.push_back(code[7:0]);
          fb.push_back({code[11:8], 4'(len - lzss_pkg::MIN_MATCH)});
          produced_g += len;
        end else begin
          fb.push_back(8'($urandom_range(0, 255)));
          produced_g++;
        end
      end
      // sometimes cut the closing back-reference short
      if (last_ref && $urandom_range(0, 4) == 0) void'(fb.pop_back());
    end
    n_items = fb.size();
    send_frame(fb);
  endtask

  task automatic test_random_frames();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: set_capacity(24'($urandom_range(0, 80)));
        1: set_capacity(24'($urandom_range(0, 24'hFFFFFF)));
        2: set_capacity(lzss_pkg::CAP_RESET);
        default: ;
      endcase
      random_frame(n);
      sent += n;
    end
  endtask

  initial begin
    restart_frame();
    capacity = lzss_pkg::CAP_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_register();
    test_literals_and_copies();
    src_steady = 1'b1;
    sink_steady = 1'b1;
    test_stream_end_cases();
    src_steady = 1'b0;
    sink_steady = 1'b0;
    test_offset_error();
    test_capacity();
    test_random_frames();
    settle();

    $display("Run covered %0d compressed bytes and %0d capacity writes",
             items_sent, cap_writes);
    $display("Results checked: %0d data bytes, %0d frame ends, %0d errors",
             bytes_checked, ends_checked, errors_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lzss_pkg.sv
hdl/lzss_stream_decompressor.sv
verif/tb.sv
